@@ hdl/svp_pkg.sv @@
package svp_pkg;

    localparam int WORD_W   = 32;
    localparam int CFG_W    = 31;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VISCOSITY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_DX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_DY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_DX_SQ = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_DY_SQ = 3'd5;

    localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;

    typedef struct packed {
        logic              flag;
        logic [WORD_W-1:0] val;
    } sat_t;

    // clip a wide signed value to the 32-bit word range
    function automatic sat_t sat_word(input logic signed [63:0] v);
        sat_t r;
        if ((&v[63:WORD_W-1]) || !(|v[63:WORD_W-1])) begin
            r.flag = 1'b0;
            r.val  = v[WORD_W-1:0];
        end else begin
            r.flag = 1'b1;
            r.val  = v[63] ? WORD_MIN : WORD_MAX;
        end
        return r;
    endfunction

endpackage

@@ hdl/staggered_velocity_predictor_top.sv @@
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    component, is_boundary, centre, 4 neighbors, 4 cross
// m_        out        m_valid/m_ready    predicted_velocity, saturated
// cfg_      in         cfg_wr_en          cfg_index, cfg_wr_data (no read-back)
//
// Seven register stages: a new transaction can enter every cycle while the output is not
// stalled; four of the stages (2, 3, 4 and 6) hold multiplies.
// aresetn (synchronous) clears all stage valid bits and loads the register defaults.
// Each stage holds while the stage after it is full and stalled; bubbles are squeezed out,
// so s_ready stays high while any stage ahead still has room.
module staggered_velocity_predictor_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [svp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [svp_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_component,
    input  logic                          s_is_boundary,
    input  logic signed [31:0]            s_centre,
    input  logic signed [31:0]            s_east,
    input  logic signed [31:0]            s_west,
    input  logic signed [31:0]            s_north,
    input  logic signed [31:0]            s_south,
    input  logic signed [31:0]            s_cross_a,
    input  logic signed [31:0]            s_cross_b,
    input  logic signed [31:0]            s_cross_c,
    input  logic signed [31:0]            s_cross_d,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [31:0]            m_predicted_velocity,
    output logic                          m_saturated
);
    import svp_pkg::*;

    localparam int NSTG = 7;
    localparam logic [CFG_W-1:0] ONE_RESET = CFG_W'(64'd1 << FRAC_BITS);
    localparam logic [CFG_W-1:0] DT_RESET  = CFG_W'((64'd1 << FRAC_BITS) / 100);

    function automatic logic signed [63:0] fx_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p >>> FRAC_BITS;
    endfunction

    // configuration
    logic [CFG_W-1:0] dt_reg, nu_reg, idx_reg, idy_reg, idx2_reg, idy2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dt_reg   <= DT_RESET;
            nu_reg   <= DT_RESET;
            idx_reg  <= ONE_RESET;
            idy_reg  <= ONE_RESET;
            idx2_reg <= ONE_RESET;
            idy2_reg <= ONE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TIME_STEP: dt_reg   <= cfg_wr_data;
                REG_VISCOSITY: nu_reg   <= cfg_wr_data;
                REG_INV_DX:    idx_reg  <= cfg_wr_data;
                REG_INV_DY:    idy_reg  <= cfg_wr_data;
                REG_INV_DX_SQ: idx2_reg <= cfg_wr_data;
                REG_INV_DY_SQ: idy2_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    logic signed [31:0] dt_s, nu_s, idx_s, idy_s, idx2_s, idy2_s;
    assign dt_s   = $signed({1'b0, dt_reg});
    assign nu_s   = $signed({1'b0, nu_reg});
    assign idx_s  = $signed({1'b0, idx_reg});
    assign idy_s  = $signed({1'b0, idy_reg});
    assign idx2_s = $signed({1'b0, idx2_reg});
    assign idy2_s = $signed({1'b0, idy2_reg});

    // stage valid bits and flow control
    logic [NSTG:1] vld_reg;
    logic [NSTG+1:1] en;

    always_comb begin
        en[NSTG+1] = m_ready;
        for (int k = NSTG; k >= 1; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end
    assign s_ready = en[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[1]) begin
                vld_reg[1] <= s_valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stage 1: cross average, upwind differences, second differences
    logic signed [33:0] sum4;
    logic signed [31:0] avg, ax1, ay1;
    logic signed [32:0] dx_raw, dy_raw;
    logic signed [33:0] lx_raw, ly_raw;
    sat_t dx_s, dy_s, lx_s, ly_s;

    always_comb begin
        sum4   = 34'(s_cross_a) + 34'(s_cross_b) + 34'(s_cross_c) + 34'(s_cross_d);
        avg    = sum4[33:2];
        ax1    = s_component ? avg : s_centre;
        ay1    = s_component ? s_centre : avg;
        // zero advecting velocity takes the backward difference
        dx_raw = ax1[31] ? (33'(s_east) - 33'(s_centre)) : (33'(s_centre) - 33'(s_west));
        dy_raw = ay1[31] ? (33'(s_north) - 33'(s_centre)) : (33'(s_centre) - 33'(s_south));
        lx_raw = 34'(s_east) - (34'(s_centre) <<< 1) + 34'(s_west);
        ly_raw = 34'(s_north) - (34'(s_centre) <<< 1) + 34'(s_south);
        dx_s   = sat_word(64'(dx_raw));
        dy_s   = sat_word(64'(dy_raw));
        lx_s   = sat_word(64'(lx_raw));
        ly_s   = sat_word(64'(ly_raw));
    end

    logic signed [31:0] s1_ax_reg, s1_ay_reg, s1_dx_reg, s1_dy_reg, s1_lx_reg, s1_ly_reg;
    logic signed [31:0] c_reg [1:NSTG-1];
    logic [1:NSTG-1] bnd_reg;
    logic [1:NSTG-1] sat_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            s1_ax_reg  <= ax1;
            s1_ay_reg  <= ay1;
            s1_dx_reg  <= dx_s.val;
            s1_dy_reg  <= dy_s.val;
            s1_lx_reg  <= lx_s.val;
            s1_ly_reg  <= ly_s.val;
        end
    end

    // centre, boundary and clip flag travel down the pipe
    logic [2:NSTG-1] stg_flag;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            c_reg[1]   <= s_centre;
            bnd_reg[1] <= s_is_boundary;
            sat_reg[1] <= dx_s.flag | dy_s.flag | lx_s.flag | ly_s.flag;
        end
        for (int k = 2; k <= NSTG-1; k++) begin
            if (en[k]) begin
                c_reg[k]   <= c_reg[k-1];
                bnd_reg[k] <= bnd_reg[k-1];
                sat_reg[k] <= sat_reg[k-1] | stg_flag[k];
            end
        end
    end

    // stage 2: gradients and scaled second differences
    sat_t gx_s, gy_s, lxp_s, lyp_s;
    logic signed [31:0] s2_ax_reg, s2_ay_reg, s2_gx_reg, s2_gy_reg, s2_lx_reg, s2_ly_reg;

    always_comb begin
        gx_s  = sat_word(fx_mul(s1_dx_reg, idx_s));
        gy_s  = sat_word(fx_mul(s1_dy_reg, idy_s));
        lxp_s = sat_word(fx_mul(s1_lx_reg, idx2_s));
        lyp_s = sat_word(fx_mul(s1_ly_reg, idy2_s));
    end
    assign stg_flag[2] = gx_s.flag | gy_s.flag | lxp_s.flag | lyp_s.flag;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            s2_ax_reg <= s1_ax_reg;
            s2_ay_reg <= s1_ay_reg;
            s2_gx_reg <= gx_s.val;
            s2_gy_reg <= gy_s.val;
            s2_lx_reg <= lxp_s.val;
            s2_ly_reg <= lyp_s.val;
        end
    end

    // stage 3: convection terms, Laplacian sum
    sat_t p1_s, p2_s, lap_s;
    logic signed [31:0] s3_p1_reg, s3_p2_reg, s3_lap_reg;

    always_comb begin
        p1_s  = sat_word(fx_mul(s2_ax_reg, s2_gx_reg));
        p2_s  = sat_word(fx_mul(s2_ay_reg, s2_gy_reg));
        lap_s = sat_word(64'(s2_lx_reg) + 64'(s2_ly_reg));
    end
    assign stg_flag[3] = p1_s.flag | p2_s.flag | lap_s.flag;

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            s3_p1_reg  <= p1_s.val;
            s3_p2_reg  <= p2_s.val;
            s3_lap_reg <= lap_s.val;
        end
    end

    // stage 4: convection sum, viscous term
    sat_t conv_s, nl_s;
    logic signed [31:0] s4_conv_reg, s4_nl_reg;

    always_comb begin
        conv_s = sat_word(64'(s3_p1_reg) + 64'(s3_p2_reg));
        nl_s   = sat_word(fx_mul(nu_s, s3_lap_reg));
    end
    assign stg_flag[4] = conv_s.flag | nl_s.flag;

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            s4_conv_reg <= conv_s.val;
            s4_nl_reg   <= nl_s.val;
        end
    end

    // stage 5: right-hand side
    sat_t rhs_s;
    logic signed [31:0] s5_rhs_reg;

    assign rhs_s       = sat_word(64'(s4_nl_reg) - 64'(s4_conv_reg));
    assign stg_flag[5] = rhs_s.flag;

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            s5_rhs_reg <= rhs_s.val;
        end
    end

    // stage 6: scale by dt
    sat_t inc_s;
    logic signed [31:0] s6_inc_reg;

    assign inc_s       = sat_word(fx_mul(dt_s, s5_rhs_reg));
    assign stg_flag[6] = inc_s.flag;

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            s6_inc_reg <= inc_s.val;
        end
    end

    // stage 7: final update, boundary bypass, output register
    sat_t res_s;
    logic signed [31:0] out_val_reg;
    logic out_sat_reg;

    assign res_s = sat_word(64'(c_reg[NSTG-1]) + 64'(s6_inc_reg));

    always_ff @(posedge aclk) begin
        if (en[NSTG]) begin
            if (bnd_reg[NSTG-1]) begin
                out_val_reg <= c_reg[NSTG-1];
                out_sat_reg <= 1'b0;
            end else begin
                out_val_reg <= res_s.val;
                out_sat_reg <= sat_reg[NSTG-1] | res_s.flag;
            end
        end
    end

    assign m_valid              = vld_reg[NSTG];
    assign m_predicted_velocity = out_val_reg;
    assign m_saturated          = out_sat_reg;

endmodule

@@ hdl/svp_checker.sv @@
module svp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_predicted_velocity,
    input logic        m_saturated
);

    // pipeline comes up empty
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high right after reset");

    // an empty output stage means every stage can take data
    a_ready_when_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low with empty output stage");

    // downstream taking data lets the whole pipe advance
    a_ready_follows_sink: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("s_ready low while m_ready high");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_predicted_velocity)
                                && $stable(m_saturated))
        else $error("output transaction changed while stalled");

endmodule

bind staggered_velocity_predictor_top svp_checker u_svp_checker (
    .aclk                 (aclk),
    .aresetn              (aresetn),
    .s_ready              (s_ready),
    .m_valid              (m_valid),
    .m_ready              (m_ready),
    .m_predicted_velocity (m_predicted_velocity),
    .m_saturated          (m_saturated)
);

@@ sim/staggered_velocity_predictor_top_test.sv @@
module staggered_velocity_predictor_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import svp_pkg::*;

    localparam int FRAC = 16;
    localparam int TIMEOUT_CYCLES = 200_000;
    localparam longint WORD_HI = 64'sd2147483647;
    localparam longint WORD_LO = -64'sd2147483648;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE = 32'sd65536;
    localparam logic [CFG_W-1:0] C_MAX = 31'h7FFF_FFFF;
    localparam logic [CFG_W-1:0] C_ONE = 31'd65536;
    localparam logic [CFG_W-1:0] C_CENTI = 31'd655;
    // indexes past the last register: writes there must not change anything
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int LONG_HOLD_CYCLES = 200;

    typedef enum {PT_SMOOTH, PT_FULL, PT_CORNER} point_style_t;
    typedef enum {RX_STREAM, RX_HALF, RX_SPARSE, RX_JITTER} rx_mode_t;

    typedef struct {
        bit                 component;
        bit                 is_boundary;
        bit                 drain_first;
        logic signed [31:0] centre;
        logic signed [31:0] east;
        logic signed [31:0] west;
        logic signed [31:0] north;
        logic signed [31:0] south;
        logic signed [31:0] cross_a;
        logic signed [31:0] cross_b;
        logic signed [31:0] cross_c;
        logic signed [31:0] cross_d;
    } grid_point_t;

    typedef struct {
        logic signed [31:0] velocity;
        bit                 saturated;
    } velocity_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_wr_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_component = 1'b0;
    logic                   s_is_boundary = 1'b0;
    logic signed [31:0]     s_centre = '0;
    logic signed [31:0]     s_east = '0;
    logic signed [31:0]     s_west = '0;
    logic signed [31:0]     s_north = '0;
    logic signed [31:0]     s_south = '0;
    logic signed [31:0]     s_cross_a = '0;
    logic signed [31:0]     s_cross_b = '0;
    logic signed [31:0]     s_cross_c = '0;
    logic signed [31:0]     s_cross_d = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic signed [31:0]     m_predicted_velocity;
    logic                   m_saturated;

    logic [CFG_W-1:0] coeff [0:5];
    grid_point_t      point_q[$];
    velocity_t        velocity_q[$];
    grid_point_t      offered;
    int               accepted_count = 0;
    int               burst_left = 0;
    int               gap_left = 0;
    int               hold_left = 0;
    int               next_hold_at = 60;
    int               stall_seg_left = 0;
    rx_mode_t         rx_mode = RX_STREAM;
    int               mismatches = 0;

    staggered_velocity_predictor_top #(.FRAC_BITS(FRAC)) dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic longint clip_word(input longint v, inout bit clipped);
        if (v > WORD_HI) begin
            clipped = 1'b1;
            return WORD_HI;
        end
        if (v < WORD_LO) begin
            clipped = 1'b1;
            return WORD_LO;
        end
        return v;
    endfunction

    // fixed-point product, floored, then clipped
    function automatic longint fx_product(input longint p, input longint q, inout bit clipped);
        longint r;
        r = (p * q) >>> FRAC;
        return clip_word(r, clipped);
    endfunction

    function automatic velocity_t predict_velocity(input grid_point_t pt);
        velocity_t r;
        bit     clipped;
        longint c, e, w, n, s, avg, ax, ay, dxv, dyv, gx, gy, t1, t2, conv;
        longint lx, ly, l1, l2, lap, visc, rhs, step;
        clipped = 1'b0;
        c = longint'(pt.centre);
        e = longint'(pt.east);
        w = longint'(pt.west);
        n = longint'(pt.north);
        s = longint'(pt.south);
        if (pt.is_boundary) begin
            r.velocity = pt.centre;
            r.saturated = 1'b0;
            return r;
        end
        avg = (longint'(pt.cross_a) + longint'(pt.cross_b) + longint'(pt.cross_c)
               + longint'(pt.cross_d)) >>> 2;
        ax = pt.component ? avg : c;
        ay = pt.component ? c : avg;
        // zero advecting velocity takes the backward difference
        dxv = clip_word((ax >= 0) ? c - w : e - c, clipped);
        dyv = clip_word((ay >= 0) ? c - s : n - c, clipped);
        gx = fx_product(dxv, longint'(coeff[REG_INV_DX]), clipped);
        t1 = fx_product(ax, gx, clipped);
        gy = fx_product(dyv, longint'(coeff[REG_INV_DY]), clipped);
        t2 = fx_product(ay, gy, clipped);
        conv = clip_word(t1 + t2, clipped);
        lx = clip_word(e - 2 * c + w, clipped);
        ly = clip_word(n - 2 * c + s, clipped);
        l1 = fx_product(lx, longint'(coeff[REG_INV_DX_SQ]), clipped);
        l2 = fx_product(ly, longint'(coeff[REG_INV_DY_SQ]), clipped);
        lap = clip_word(l1 + l2, clipped);
        visc = fx_product(longint'(coeff[REG_VISCOSITY]), lap, clipped);
        rhs = clip_word(visc - conv, clipped);
        step = fx_product(longint'(coeff[REG_TIME_STEP]), rhs, clipped);
        r.velocity = 32'(clip_word(c + step, clipped));
        r.saturated = clipped;
        return r;
    endfunction

    function automatic grid_point_t make_point(input bit comp, input bit bnd,
                                               input logic signed [31:0] c, e, w, n, s,
                                               input logic signed [31:0] a, b, cc, d);
        grid_point_t pt;
        pt.component = comp;
        pt.is_boundary = bnd;
        pt.drain_first = 1'b0;
        pt.centre = c;
        pt.east = e;
        pt.west = w;
        pt.north = n;
        pt.south = s;
        pt.cross_a = a;
        pt.cross_b = b;
        pt.cross_c = cc;
        pt.cross_d = d;
        return pt;
    endfunction

    function automatic logic signed [31:0] random_word(input point_style_t style,
                                                      input logic signed [31:0] base);
        case (style)
            PT_SMOOTH: return base + $signed($urandom_range(0, 65536)) - 32768;
            PT_FULL:   return $urandom;
            default: begin
                case ($urandom_range(0, 5))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return '0;
                    3: return Q_ONE;
                    4: return -Q_ONE;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    function automatic grid_point_t random_point();
        grid_point_t        pt;
        point_style_t       style;
        logic signed [31:0] base, cbase;
        int                 pick;
        pick = $urandom_range(0, 9);
        style = (pick < 6) ? PT_SMOOTH : (pick < 8) ? PT_FULL : PT_CORNER;
        base = $signed($urandom_range(0, 1048576)) - 524288;
        cbase = $signed($urandom_range(0, 1048576)) - 524288;
        pt.component = 1'($urandom_range(0, 1));
        pt.is_boundary = ($urandom_range(0, 9) == 0);
        pt.drain_first = ($urandom_range(0, 59) == 0);
        pt.centre = random_word(style, base);
        pt.east = random_word(style, base);
        pt.west = random_word(style, base);
        pt.north = random_word(style, base);
        pt.south = random_word(style, base);
        pt.cross_a = random_word(style, cbase);
        pt.cross_b = random_word(style, cbase);
        pt.cross_c = random_word(style, cbase);
        pt.cross_d = random_word(style, cbase);
        return pt;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wr_data <= data;
        if (index <= REG_INV_DY_SQ)
            coeff[index] = data;
    endtask

    task automatic program_coeffs(input logic [CFG_W-1:0] dt, nu, idx, idy, idx2, idy2);
        write_reg(REG_TIME_STEP, dt);
        write_reg(REG_VISCOSITY, nu);
        write_reg(REG_INV_DX, idx);
        write_reg(REG_INV_DY, idy);
        write_reg(REG_INV_DX_SQ, idx2);
        write_reg(REG_INV_DY_SQ, idy2);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // sampled mid-cycle so the driver and monitor updates of this edge have settled
    task automatic wait_idle();
        do
            @(negedge aclk);
        while (point_q.size() != 0 || s_valid || velocity_q.size() != 0);
    endtask

    task automatic queue_random(input int count);
        repeat (count) point_q.push_back(random_point());
    endtask

    function automatic void flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%t mismatch: %s", $realtime, msg);
    endfunction

    // sender: bursts of transactions separated by idle gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                velocity_q.push_back(predict_velocity(offered));
                accepted_count++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0 || point_q.size() == 0 ||
                    (point_q[0].drain_first && velocity_q.size() != 0)) begin
                    if (gap_left > 0)
                        gap_left--;
                    s_valid <= 1'b0;
                end else begin
                    offered = point_q.pop_front();
                    s_valid <= 1'b1;
                    s_component <= offered.component;
                    s_is_boundary <= offered.is_boundary;
                    s_centre <= offered.centre;
                    s_east <= offered.east;
                    s_west <= offered.west;
                    s_north <= offered.north;
                    s_south <= offered.south;
                    s_cross_a <= offered.cross_a;
                    s_cross_b <= offered.cross_b;
                    s_cross_c <= offered.cross_c;
                    s_cross_d <= offered.cross_d;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        if ($urandom_range(0, 3) == 0) begin
                            burst_left = $urandom_range(30, 80);
                            gap_left = 0;
                        end else begin
                            burst_left = $urandom_range(1, 12);
                            gap_left = $urandom_range(0, 10);
                        end
                    end
                end
            end
        end
    end

    // receiver: stall pattern in segments, plus long hold-offs to back up the pipeline
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (accepted_count >= next_hold_at) begin
            hold_left = LONG_HOLD_CYCLES;
            next_hold_at += 200;
            m_ready <= 1'b0;
        end else begin
            if (stall_seg_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                stall_seg_left = $urandom_range(8, 64);
            end
            stall_seg_left--;
            case (rx_mode)
                RX_STREAM: m_ready <= 1'b1;
                RX_HALF:   m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default:   m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        velocity_t want;
        if (aresetn && m_valid && m_ready) begin
            if (velocity_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected transaction velocity=%0d saturated=%0b",
                                        m_predicted_velocity, m_saturated));
            end else begin
                want = velocity_q.pop_front();
                if (m_predicted_velocity !== want.velocity || m_saturated !== want.saturated)
                    flag_mismatch($sformatf("velocity exp %0d got %0d, saturated exp %0b got %0b",
                                            want.velocity, m_predicted_velocity,
                                            want.saturated, m_saturated));
            end
        end
    end

    initial begin
        grid_point_t pt;
        coeff[REG_TIME_STEP] = C_CENTI;
        coeff[REG_VISCOSITY] = C_CENTI;
        coeff[REG_INV_DX] = C_ONE;
        coeff[REG_INV_DY] = C_ONE;
        coeff[REG_INV_DX_SQ] = C_ONE;
        coeff[REG_INV_DY_SQ] = C_ONE;

        // boundary points pass the centre through
        point_q.push_back(make_point(0, 1, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                     Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        point_q.push_back(make_point(1, 1, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                     Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        point_q.push_back(make_point(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        point_q.push_back(make_point(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // zero advecting velocity on u: backward in x
        point_q.push_back(make_point(0, 0, 0, Q_ONE, -Q_ONE, 2 * Q_ONE, -Q_ONE,
                                     Q_ONE, Q_ONE, 0, 0));
        // v cross sum zero, just below zero and just above zero
        point_q.push_back(make_point(1, 0, Q_ONE, 3 * Q_ONE, -Q_ONE, 0, 2 * Q_ONE,
                                     Q_ONE, -Q_ONE, Q_ONE, -Q_ONE));
        point_q.push_back(make_point(1, 0, Q_ONE, 3 * Q_ONE, -Q_ONE, 0, 2 * Q_ONE,
                                     0, 0, 0, -1));
        point_q.push_back(make_point(1, 0, Q_ONE, 3 * Q_ONE, -Q_ONE, 0, 2 * Q_ONE,
                                     1, 1, 1, 0));
        // negative advecting velocities take forward differences
        point_q.push_back(make_point(0, 0, -Q_ONE, 2 * Q_ONE, -3 * Q_ONE, Q_ONE, 0,
                                     -Q_ONE, -Q_ONE, -2 * Q_ONE, 0));
        point_q.push_back(make_point(1, 0, -2 * Q_ONE, Q_ONE, 0, -Q_ONE, Q_ONE,
                                     Q_ONE, 2 * Q_ONE, 0, Q_ONE));
        pt = make_point(0, 0, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        pt.drain_first = 1'b1;
        point_q.push_back(pt);
        point_q.push_back(make_point(1, 0, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                     Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        point_q.push_back(make_point(0, 0, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                     Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        point_q.push_back(make_point(1, 0, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                     Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        point_q.push_back(make_point(0, 0, Q_MAX, 0, 0, 0, 0, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        point_q.push_back(make_point(1, 0, Q_MIN, 0, 0, 0, 0, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        point_q.push_back(make_point(0, 0, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN,
                                     Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        point_q.push_back(make_point(1, 1, $urandom, $urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom, $urandom));
        point_q.push_back(make_point(0, 0, 32'sd98304, 32'sd131072, 32'sd65536, 32'sd81920,
                                     32'sd114688, 32'sd16384, 32'sd24576, 32'sd8192,
                                     -32'sd4096));
        point_q.push_back(make_point(1, 0, -32'sd49152, -32'sd32768, -32'sd65536,
                                     32'sd16384, -32'sd98304, 32'sd131072, 32'sd98304,
                                     32'sd114688, 32'sd65536));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        queue_random(75);
        wait_idle();
        program_coeffs(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
        queue_random(60);
        wait_idle();
        program_coeffs('0, '0, '0, '0, '0, '0);
        queue_random(60);
        wait_idle();
        program_coeffs(CFG_W'($urandom_range(100, 6554)), CFG_W'($urandom_range(0, 6554)),
                       CFG_W'($urandom_range(1, 16) * C_ONE),
                       CFG_W'($urandom_range(1, 16) * C_ONE),
                       CFG_W'($urandom_range(1, 256) * C_ONE),
                       CFG_W'($urandom_range(1, 256) * C_ONE));
        queue_random(60);
        wait_idle();
        program_coeffs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                       CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
        queue_random(60);
        wait_idle();
        program_coeffs(C_MAX, '0, '0, C_MAX, 31'd1, C_ONE);
        write_reg(REG_SPARE_LO, CFG_W'($urandom));
        write_reg(REG_SPARE_HI, CFG_W'($urandom));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        queue_random(60);
        wait_idle();
        program_coeffs(C_CENTI, C_CENTI, C_ONE, C_ONE, C_ONE, C_ONE);
        queue_random(60);
        wait_idle();

        repeat (20) @(posedge aclk);
        if (mismatches == 0 && velocity_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * 12);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
